[rtl/core/bia_pkg.sv]
package bia_pkg;

	localparam int unsigned NUM_IDS_DEF    = 256;
	localparam int unsigned WORD_BITS      = 64;
	localparam int unsigned BIT_W          = 6;
	localparam int unsigned WORD_IDX_MAX_W = 6;

	localparam logic [1:0] STATUS_SUCCESS     = 2'd0;
	localparam logic [1:0] STATUS_EMPTY       = 2'd1;
	localparam logic [1:0] STATUS_NOT_IN_USE  = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic       next_word;
		logic       commit_alloc;
		logic       commit_free;
		logic       emit;
		logic [1:0] status;
	} dp_ctrl_t;

	typedef struct packed {
		logic free_cmd;
		logic word_nonzero;
		logic last_word;
		logic release_bad;
	} dp_stat_t;

	function automatic logic [WORD_BITS-1:0] word_reset(input int unsigned w,
		input int unsigned num_ids);
		int unsigned rem;
		rem = num_ids - w * WORD_BITS;
		if (rem >= WORD_BITS) begin
			return '1;
		end
		return (64'd1 << rem) - 64'd1;
	endfunction

	function automatic logic [BIT_W-1:0] lowest_index(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] lowbit;
		logic [BIT_W-1:0]     idx;
		lowbit = v & (~v + 64'd1);
		idx    = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			if (lowbit[p]) begin
				idx = idx | BIT_W'(p);
			end
		end
		return idx;
	endfunction

endpackage

[rtl/core/bia_ram.sv]
module bia_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 4,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/bia_ctrl.sv]
module bia_ctrl
	import bia_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dp_stat_t stat,
	output dp_ctrl_t ctrl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.free_cmd || stat.word_nonzero || stat.last_word) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.status = STATUS_SUCCESS;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				ctrl.load = start;
			end
			ST_READ: begin
				ctrl.rd_en = 1'b1;
			end
			ST_CHECK: begin
				if (stat.free_cmd) begin
					ctrl.emit = 1'b1;
					if (stat.release_bad) begin
						ctrl.status = STATUS_NOT_IN_USE;
					end else begin
						ctrl.commit_free = 1'b1;
					end
				end else if (stat.word_nonzero) begin
					ctrl.commit_alloc = 1'b1;
					ctrl.emit = 1'b1;
				end else if (stat.last_word) begin
					ctrl.emit = 1'b1;
					ctrl.status = STATUS_EMPTY;
				end else begin
					ctrl.next_word = 1'b1;
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

[rtl/core/bia_datapath.sv]
module bia_datapath
	import bia_pkg::*;
#(
	parameter int unsigned NUM_IDS = NUM_IDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       command,
	input  logic [7:0] release_id,
	input  dp_ctrl_t   ctrl,
	output dp_stat_t   stat,
	output logic       done,
	output logic [1:0] status,
	output logic [7:0] granted_id,
	output logic [8:0] in_use_count
);

	localparam int unsigned MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned CNT_W     = $clog2(NUM_IDS + 1);

	logic                  cmd_q;
	logic [7:0]            rid_q;
	logic [WW-1:0]         word_q;
	logic [MAP_WORDS-1:0]  valid_q;
	logic [CNT_W-1:0]      used_q;
	logic [CNT_W-1:0]      used_d;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [7:0]            granted_q;
	logic [8:0]            count_q;

	logic [WORD_BITS-1:0]  rdata;
	logic [WORD_BITS-1:0]  eff_word;
	logic [WORD_BITS-1:0]  wdata;
	logic [WORD_BITS-1:0]  rid_mask;
	logic [BIT_W-1:0]      low_idx;
	logic                  we;
	logic                  rid_ok;
	logic                  in_rid_ok;
	logic [WORD_IDX_MAX_W+BIT_W-1:0] gid;
	logic [15:0]           cnt_ext;

	assign in_rid_ok = 13'(release_id) < 13'(NUM_IDS);
	assign rid_ok    = 13'(rid_q) < 13'(NUM_IDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctrl.load) begin
			if (command == CMD_FREE && in_rid_ok) begin
				word_q <= WW'(release_id[7:6]);
			end else begin
				word_q <= '0;
			end
		end else if (ctrl.next_word) begin
			word_q <= word_q + WW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= command;
			rid_q <= release_id;
		end
	end

	assign we = ctrl.commit_alloc | ctrl.commit_free;

	bia_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (word_q),
		.wdata (wdata),
		.re    (ctrl.rd_en),
		.raddr (word_q),
		.rdata (rdata)
	);

	assign eff_word = valid_q[word_q] ? rdata : word_reset(int'(word_q), NUM_IDS);
	assign low_idx  = lowest_index(eff_word);
	assign rid_mask = 64'd1 << rid_q[BIT_W-1:0];
	assign wdata    = ctrl.commit_alloc ? (eff_word & ~(64'd1 << low_idx))
	                                    : (eff_word | rid_mask);
	assign gid      = {WORD_IDX_MAX_W'(word_q), low_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[word_q] <= 1'b1;
		end
	end

	always_comb begin
		used_d = used_q;
		if (ctrl.commit_alloc) begin
			used_d = used_q + CNT_W'(1);
		end else if (ctrl.commit_free && used_q != '0) begin
			used_d = used_q - CNT_W'(1);
		end
	end

	assign cnt_ext = 16'(used_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			used_q <= used_d;
			done_q <= ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			status_q  <= ctrl.status;
			granted_q <= ctrl.commit_alloc ? gid[7:0] : 8'd0;
			count_q   <= cnt_ext[8:0];
		end
	end

	assign stat.free_cmd     = (cmd_q == CMD_FREE);
	assign stat.word_nonzero = |eff_word;
	assign stat.last_word    = (word_q == WW'(MAP_WORDS - 1));
	assign stat.release_bad  = !rid_ok || eff_word[rid_q[BIT_W-1:0]];

	assign done         = done_q;
	assign status       = status_q;
	assign granted_id   = granted_q;
	assign in_use_count = count_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(NUM_IDS))
		else $error("in-use count above pool size");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |=> done_q)
		else $error("result strobe missing after emit");

	a_alloc_word: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit_alloc |-> (|eff_word) && !ctrl.commit_free && ctrl.emit)
		else $error("allocate committed without a free bit");

	a_free_bit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit_free |-> rid_ok && !eff_word[rid_q[BIT_W-1:0]])
		else $error("free committed on an identifier not in use");

	a_empty_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != STATUS_SUCCESS) |-> (granted_q == 8'd0))
		else $error("nonzero identifier on a failed command");
`endif

endmodule

[rtl/core/bitmap_id_allocator_top.sv]
// Channel   Handshake                 Fields
// command   start, busy               command, release_id
// result    done (one-cycle strobe)   status, granted_id, in_use_count
//
// A command transfers when start is high and busy is low.
// Free: map read, check, then the result is registered onto the done strobe.
// Allocate: the scan reads one 64-bit word of the map RAM at a time from word 0,
// a read then a check, until a word has a free bit or the last word is checked.
// Reset needs no clearing pass: per-word valid bits return the reset map.
// The receiver cannot stall; done is high for one cycle only, and the result fields hold until the next result.
module bitmap_id_allocator_top
	import bia_pkg::*;
#(
	parameter int unsigned NUM_IDS = NUM_IDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       command,
	input  logic [7:0] release_id,
	output logic       done,
	output logic [1:0] status,
	output logic [7:0] granted_id,
	output logic [8:0] in_use_count
);

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	bia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	bia_datapath #(
		.NUM_IDS (NUM_IDS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.release_id   (release_id),
		.ctrl         (ctrl),
		.stat         (stat),
		.done         (done),
		.status       (status),
		.granted_id   (granted_id),
		.in_use_count (in_use_count)
	);

endmodule

[tb/bitmap_id_allocator_checker.sv]
`timescale 1ns / 100ps

module bitmap_id_allocator_checker
	import bia_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic       command,
	input  logic [7:0] release_id,
	input  logic       done,
	input  logic [1:0] status,
	input  logic [7:0] granted_id,
	input  logic [8:0] in_use_count,
	output int         errors,
	output int         pending,
	output int         grants,
	output int         releases,
	output int         exhausted,
	output int         rejected
);

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] id;
		logic [8:0] count;
	} reply_t;

	logic [NUM_IDS_DEF-1:0] free_ids = '1;
	int                     ids_in_use = 0;
	reply_t                 replies_due[$];
	reply_t                 want_reply;
	reply_t                 next_reply;
	logic                   hit;
	int                     pick;

	task automatic check_field(input string what, input logic [8:0] want, input logic [8:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_ids   = '1;
			ids_in_use = 0;
			replies_due.delete();
			errors     = 0;
			grants     = 0;
			releases   = 0;
			exhausted  = 0;
			rejected   = 0;
			pending   <= 0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, status %0d id %0d count %0d",
						$time, status, granted_id, in_use_count);
				end else begin
					want_reply = replies_due.pop_front();
					check_field("status", 9'(want_reply.status), 9'(status));
					check_field("granted_id", 9'(want_reply.id), 9'(granted_id));
					check_field("in_use_count", want_reply.count, in_use_count);
				end
			end
			if (start && !busy) begin
				next_reply = '0;
				if (command == CMD_ALLOC) begin
					hit  = 1'b0;
					pick = 0;
					for (int i = 0; i < NUM_IDS_DEF; i++) begin
						if (!hit && free_ids[i]) begin
							hit  = 1'b1;
							pick = i;
						end
					end
					if (hit) begin
						free_ids[pick] = 1'b0;
						ids_in_use++;
						next_reply.status = STATUS_SUCCESS;
						next_reply.id     = pick[7:0];
						grants++;
					end else begin
						next_reply.status = STATUS_EMPTY;
						exhausted++;
					end
				end else begin
					if (int'(release_id) >= NUM_IDS_DEF || free_ids[release_id]) begin
						next_reply.status = STATUS_NOT_IN_USE;
						rejected++;
					end else begin
						free_ids[release_id] = 1'b1;
						if (ids_in_use > 0) begin
							ids_in_use--;
						end
						next_reply.status = STATUS_SUCCESS;
						releases++;
					end
				end
				next_reply.count = ids_in_use[8:0];
				replies_due.push_back(next_reply);
			end
			pending <= replies_due.size();
		end
	end

endmodule

[tb/bitmap_id_allocator_top_tb.sv]
`timescale 1ns / 100ps

module bitmap_id_allocator_top_tb;
	import bia_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1500;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       command;
	logic [7:0] release_id;
	logic       done;
	logic [1:0] status;
	logic [7:0] granted_id;
	logic [8:0] in_use_count;

	int errors;
	int pending;
	int grants;
	int releases;
	int exhausted;
	int rejected;

	logic [NUM_IDS_DEF-1:0] held = '0;
	int                     sent = 0;
	int                     stall_cycles = 0;
	int                     roll;
	bit                     quiet = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	bitmap_id_allocator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.release_id   (release_id),
		.done         (done),
		.status       (status),
		.granted_id   (granted_id),
		.in_use_count (in_use_count)
	);

	bitmap_id_allocator_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.release_id   (release_id),
		.done         (done),
		.status       (status),
		.granted_id   (granted_id),
		.in_use_count (in_use_count),
		.errors       (errors),
		.pending      (pending),
		.grants       (grants),
		.releases     (releases),
		.exhausted    (exhausted),
		.rejected     (rejected)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic issue(input logic cmd, input logic [7:0] id);
		bit taken;
		while (!quiet && $urandom_range(0, 99) < 15) begin
			start      <= 1'b0;
			command    <= 1'($urandom_range(0, 1));
			release_id <= 8'($urandom_range(0, 255));
			@(posedge clk);
		end
		start      <= 1'b1;
		command    <= cmd;
		release_id <= id;
		do @(posedge clk); while (busy);
		sent++;
		if (cmd == CMD_ALLOC) begin
			taken = 1'b0;
			for (int k = 0; k < NUM_IDS_DEF; k++) begin
				if (!taken && !held[k]) begin
					held[k] = 1'b1;
					taken   = 1'b1;
				end
			end
		end else begin
			held[id] = 1'b0;
		end
	endtask

	function automatic logic [7:0] pick_held();
		int base;
		base = $urandom_range(0, NUM_IDS_DEF - 1);
		for (int k = 0; k < NUM_IDS_DEF; k++) begin
			if (held[(base + k) % NUM_IDS_DEF]) begin
				return 8'((base + k) % NUM_IDS_DEF);
			end
		end
		return 8'(base);
	endfunction

	task automatic release_held();
		issue(CMD_FREE, pick_held());
	endtask

	task automatic noise();
		issue(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		command    = CMD_ALLOC;
		release_id = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_FREE, 8'd0);
		issue(CMD_FREE, 8'd255);
		issue(CMD_ALLOC, 8'd0);
		issue(CMD_ALLOC, 8'd255);
		issue(CMD_ALLOC, 8'hAA);
		issue(CMD_FREE, 8'd1);
		issue(CMD_FREE, 8'd1);
		issue(CMD_ALLOC, 8'h55);
		issue(CMD_FREE, 8'd0);
		issue(CMD_FREE, 8'd2);
		issue(CMD_ALLOC, 8'd0);
		issue(CMD_FREE, 8'hAA);
		issue(CMD_FREE, 8'h55);
		issue(CMD_FREE, 8'd0);
		issue(CMD_FREE, 8'd1);
		issue(CMD_FREE, 8'd0);

		while (sent < RANDOM_ITEMS) begin
			quiet = (sent >= 600 && sent < 900);
			while ($countones(held) < NUM_IDS_DEF) begin
				roll = $urandom_range(0, 99);
				if (roll < 80) begin
					issue(CMD_ALLOC, 8'($urandom_range(0, 255)));
				end else if (roll < 92) begin
					release_held();
				end else begin
					noise();
				end
				quiet = (sent >= 600 && sent < 900);
			end
			repeat ($urandom_range(3, 10)) issue(CMD_ALLOC, 8'($urandom_range(0, 255)));
			while ($countones(held) != 0) begin
				roll = $urandom_range(0, 99);
				if (roll < 80) begin
					release_held();
				end else if (roll < 90) begin
					issue(CMD_ALLOC, 8'($urandom_range(0, 255)));
				end else begin
					noise();
				end
				quiet = (sent >= 600 && sent < 900);
			end
			repeat ($urandom_range(3, 10)) issue(CMD_FREE, 8'($urandom_range(0, 255)));
			repeat (50) begin
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					issue(CMD_ALLOC, 8'($urandom_range(0, 255)));
				end else if (roll < 90) begin
					release_held();
				end else begin
					noise();
				end
				quiet = (sent >= 600 && sent < 900);
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d commands: %0d grants, %0d releases,", sent, grants, releases);
		$display("%0d allocates on a full pool, %0d frees of IDs not in use.",
			exhausted, rejected);
		if (pending != 0) begin
			$display("%0d results never arrived", pending);
		end
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/bia_pkg.sv
rtl/core/bia_ram.sv
rtl/core/bia_ctrl.sv
rtl/core/bia_datapath.sv
rtl/core/bitmap_id_allocator_top.sv
tb/bitmap_id_allocator_checker.sv
tb/bitmap_id_allocator_top_tb.sv
